[design/pfc_pkg.sv]
// ----------------------------------------------------------------------------
// pfc_pkg: shared types and constants of the page-frame cache
// Frame count, page id width, request and result words, the search carry
// that walks the frame cells and the update command broadcast to them.
// ----------------------------------------------------------------------------
`default_nettype none

package pfc_pkg;

  localparam int FRAMES       = 16;
  localparam int PAGE_ID_BITS = 32;
  localparam int FRAME_IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int NU_W         = $clog2(FRAMES + 1);

  typedef logic [FRAME_IDX_W-1:0]  idx_t;
  typedef logic [FRAME_IDX_W-1:0]  rank_t;
  typedef logic [PAGE_ID_BITS-1:0] tag_t;
  typedef logic [NU_W-1:0]         nu_t;

  // request kinds
  localparam logic [1:0] KIND_FETCH  = 2'd0;
  localparam logic [1:0] KIND_CREATE = 2'd1;
  localparam logic [1:0] KIND_FLUSH  = 2'd2;

  // result status
  localparam logic [1:0] ST_HIT    = 2'd0;
  localparam logic [1:0] ST_PLACED = 2'd1;
  localparam logic [1:0] ST_NOFRM  = 2'd2;
  localparam logic [1:0] ST_NONRES = 2'd3;

  // fill orders
  localparam logic [1:0] FILL_NONE = 2'd0;
  localparam logic [1:0] FILL_READ = 2'd1;
  localparam logic [1:0] FILL_ZERO = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] page_id;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  frame;
    logic        writeback_valid;
    logic [31:0] writeback_page;
    logic [1:0]  fill_action;
  } out_word_t;

  // search carry handed from cell to cell
  typedef struct packed {
    logic       go;
    logic [1:0] kind;
    tag_t       id;
    logic       hit;
    idx_t       hit_frame;
    rank_t      hit_rank;
    rank_t      best_rank;
    idx_t       best_frame;
    logic       best_dirty;
    tag_t       best_tag;
  } search_t;

  typedef enum logic [1:0] {
    RANK_KEEP   = 2'd0,
    RANK_RECENT = 2'd1,
    RANK_FRESH  = 2'd2
  } rank_op_t;

  // update command broadcast to all cells
  typedef struct packed {
    logic     en;
    idx_t     sel;
    rank_op_t rank_op;
    rank_t    ref_rank;
    logic     tag_we;
    tag_t     tag;
    logic     dirty_we;
    logic     dirty;
    logic     valid_set;
  } upd_t;

  function automatic tag_t id_to_tag(input logic [31:0] p);
    logic [PAGE_ID_BITS+31:0] e;
    e = {{PAGE_ID_BITS{1'b0}}, p};
    return e[PAGE_ID_BITS-1:0];
  endfunction

  function automatic logic [31:0] tag_to_id(input tag_t t);
    logic [PAGE_ID_BITS+31:0] e;
    e = {32'b0, t};
    return e[31:0];
  endfunction

  function automatic logic [3:0] idx_to_frame(input idx_t i);
    logic [FRAME_IDX_W+3:0] e;
    e = {4'b0, i};
    return e[3:0];
  endfunction

endpackage

`default_nettype wire

[design/pfc_cell.sv]
// ----------------------------------------------------------------------------
// pfc_cell: one frame of the directory
// Holds tag, valid, dirty and recency rank of its frame. Folds its frame
// into the search carry and passes it on registered; applies broadcast
// updates.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_cell (
  input  wire              clk,
  input  wire              rst_n,
  input  pfc_pkg::idx_t    idx,
  input  pfc_pkg::search_t carry_in,
  output pfc_pkg::search_t carry_out,
  input  pfc_pkg::upd_t    upd
);
  import pfc_pkg::*;

  logic    valid_r, valid_nxt;
  logic    dirty_r, dirty_nxt;
  rank_t   rank_r, rank_nxt;
  tag_t    tag_r, tag_nxt;
  search_t carry_r, carry_nxt;

  always_comb begin
    carry_nxt = carry_in;
    if (carry_in.go && valid_r) begin
      // first matching frame wins
      if (!carry_in.hit && tag_r == carry_in.id) begin
        carry_nxt.hit       = 1'b1;
        carry_nxt.hit_frame = idx;
        carry_nxt.hit_rank  = rank_r;
      end
      if (rank_r > carry_in.best_rank) begin
        carry_nxt.best_rank  = rank_r;
        carry_nxt.best_frame = idx;
        carry_nxt.best_dirty = dirty_r;
        carry_nxt.best_tag   = tag_r;
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    dirty_nxt = dirty_r;
    rank_nxt  = rank_r;
    tag_nxt   = tag_r;
    if (upd.en) begin
      if (upd.sel == idx) begin
        if (upd.rank_op != RANK_KEEP) rank_nxt = '0;
        if (upd.tag_we) tag_nxt = upd.tag;
        if (upd.dirty_we) dirty_nxt = upd.dirty;
        if (upd.valid_set) valid_nxt = 1'b1;
      end else if (valid_r) begin
        case (upd.rank_op)
          RANK_RECENT: begin
            if (rank_r < upd.ref_rank) rank_nxt = rank_t'(rank_r + 1'b1);
          end
          RANK_FRESH: rank_nxt = rank_t'(rank_r + 1'b1);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      dirty_r <= 1'b0;
      rank_r  <= '0;
      carry_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      dirty_r <= dirty_nxt;
      rank_r  <= rank_nxt;
      carry_r <= carry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
  end

  assign carry_out = carry_r;

endmodule

`default_nettype wire

[design/page_frame_cache_lru_unit.sv]
// ----------------------------------------------------------------------------
// page_frame_cache_lru_unit: fully associative page-frame directory, LRU
// Fetch, create and flush requests against a row of frame cells; emits
// writeback and fill orders, page data moves outside.
// ----------------------------------------------------------------------------
// One request word is handled at a time. Its search walks the chain of
// FRAMES frame cells, one cell per cycle, gathering the hit and the LRU
// victim; the done state then takes the decision and updates all cells
// at once, as soon as the output register is free. A new request is
// taken only in the idle state, after that update. A result may sit in
// the output register while the next request already searches. Tags
// need no clearing pass: a frame's valid mark gates its tag.
`default_nettype none

module page_frame_cache_lru_unit (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  pfc_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output pfc_pkg::out_word_t out_data
);
  import pfc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_DONE   = 3'b100
  } state_t;

  state_t    state_r, state_nxt;
  search_t   res_r;
  nu_t       next_unused_r, next_unused_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_data_r, out_data_nxt;
  search_t   head;
  search_t   chain [FRAMES+1];
  upd_t      upd;
  logic      take;
  logic      fire;

  assign in_ready = (state_r == S_IDLE);
  assign take     = in_valid && in_ready;

  always_comb begin
    head            = '0;
    head.go         = take;
    head.kind       = in_data.kind;
    head.id         = id_to_tag(in_data.page_id);
  end

  assign chain[0] = head;

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    pfc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .idx       (idx_t'(i)),
      .carry_in  (chain[i]),
      .carry_out (chain[i+1]),
      .upd       (upd)
    );
  end

  assign fire = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // decision on the gathered search
  always_comb begin
    upd             = '0;
    upd.rank_op     = RANK_KEEP;
    out_data_nxt    = '0;
    out_data_nxt.status = ST_NONRES;
    next_unused_nxt = next_unused_r;
    if (res_r.kind == KIND_FLUSH) begin
      if (res_r.hit) begin
        out_data_nxt.status          = ST_HIT;
        out_data_nxt.frame           = idx_to_frame(res_r.hit_frame);
        out_data_nxt.writeback_valid = 1'b1;
        out_data_nxt.writeback_page  = tag_to_id(res_r.id);
        upd.sel      = res_r.hit_frame;
        upd.dirty_we = 1'b1;
        upd.dirty    = 1'b0;
      end
    end else if (res_r.kind == KIND_FETCH || res_r.kind == KIND_CREATE) begin
      if (res_r.hit) begin
        out_data_nxt.status = ST_HIT;
        out_data_nxt.frame  = idx_to_frame(res_r.hit_frame);
        upd.sel      = res_r.hit_frame;
        upd.rank_op  = RANK_RECENT;
        upd.ref_rank = res_r.hit_rank;
        if (res_r.kind == KIND_CREATE) begin
          upd.dirty_we             = 1'b1;
          upd.dirty                = 1'b1;
          out_data_nxt.fill_action = FILL_ZERO;
        end
      end else begin
        out_data_nxt.status = ST_PLACED;
        upd.tag_we   = 1'b1;
        upd.tag      = res_r.id;
        upd.dirty_we = 1'b1;
        upd.dirty    = (res_r.kind == KIND_CREATE);
        out_data_nxt.fill_action = (res_r.kind == KIND_CREATE) ? FILL_ZERO : FILL_READ;
        if (next_unused_r < nu_t'(FRAMES)) begin
          // never-used frames go first, in index order
          upd.sel         = next_unused_r[FRAME_IDX_W-1:0];
          upd.rank_op     = RANK_FRESH;
          upd.valid_set   = 1'b1;
          next_unused_nxt = nu_t'(next_unused_r + 1'b1);
        end else begin
          upd.sel      = res_r.best_frame;
          upd.rank_op  = RANK_RECENT;
          upd.ref_rank = res_r.best_rank;
          out_data_nxt.writeback_valid = res_r.best_dirty;
          out_data_nxt.writeback_page  =
            res_r.best_dirty ? tag_to_id(res_r.best_tag) : 32'b0;
        end
        out_data_nxt.frame = idx_to_frame(upd.sel);
      end
    end
    upd.en = fire;
    if (!fire) next_unused_nxt = next_unused_r;
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE:   if (take) state_nxt = S_SEARCH;
      S_SEARCH: if (chain[FRAMES].go) state_nxt = S_DONE;
      S_DONE: begin
        if (fire) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      next_unused_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      next_unused_r <= next_unused_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_SEARCH && chain[FRAMES].go) res_r <= chain[FRAMES];
    if (fire) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_tail_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    chain[FRAMES].go |-> state_r == S_SEARCH)
    else $error("search carry left the chain outside a search");

  a_nu_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_unused_r <= nu_t'(FRAMES))
    else $error("never-used frame count past frame count");

  a_fire_loads: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r && state_r == S_IDLE)
    else $error("update did not present a result word");

  a_wb_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.writeback_valid |->
      (out_data_r.status == ST_HIT || out_data_r.status == ST_PLACED))
    else $error("writeback ordered on a non-resident flush");

  a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready)
    else $error("request taken while a search is in flight");
`endif

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for page_frame_cache_lru_unit
// Drives fetch, create, flush and unused words into the directory, predicts
// each result word (hit/miss, frame, writeback and fill order) from a
// behavioral copy of the directory and checks the result stream in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import pfc_pkg::*;

  // kind code the block answers like a flush miss
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int         POOL_SIZE   = 24;
  localparam int         STALL_LIMIT = 4000;

  // directory model plus queue of expected result words
  class frame_dir_scoreboard;
    tag_t      tag_q[FRAMES];
    bit        valid_q[FRAMES];
    bit        dirty_q[FRAMES];
    rank_t     rank_q[FRAMES];
    nu_t       next_free;
    out_word_t expected_q[$];
    int        errors;

    function new();
      for (int g = 0; g < FRAMES; g++) begin
        tag_q[g]   = '0;
        valid_q[g] = 1'b0;
        dirty_q[g] = 1'b0;
        rank_q[g]  = '0;
      end
      next_free = '0;
      errors    = 0;
    endfunction

    // move frame f to rank 0, aging the frames that were more recent
    function void touch(int f);
      rank_t r;
      r = rank_q[f];
      for (int g = 0; g < FRAMES; g++)
        if (g != f && valid_q[g] && rank_q[g] < r) rank_q[g]++;
      rank_q[f] = '0;
    endfunction

    function int lru_frame();
      int    best;
      rank_t best_rank;
      best      = 0;
      best_rank = '0;
      for (int g = 0; g < FRAMES; g++)
        if (valid_q[g] && rank_q[g] > best_rank) begin
          best_rank = rank_q[g];
          best      = g;
        end
      return best;
    endfunction

    function void note_request(in_word_t w);
      out_word_t e;
      tag_t      id;
      bit        hit;
      int        hf;
      int        v;
      e   = '0;
      id  = w.page_id;
      hit = 1'b0;
      hf  = 0;
      e.status      = ST_NONRES;
      e.fill_action = FILL_NONE;
      for (int f = 0; f < FRAMES; f++)
        if (!hit && valid_q[f] && tag_q[f] == id) begin
          hit = 1'b1;
          hf  = f;
        end
      case (w.kind)
        KIND_FLUSH: begin
          // resident pages are written back even when clean; rank untouched
          if (hit) begin
            e.status          = ST_HIT;
            e.frame           = 4'(hf);
            e.writeback_valid = 1'b1;
            e.writeback_page  = 32'(tag_q[hf]);
            dirty_q[hf]       = 1'b0;
          end
        end
        KIND_FETCH, KIND_CREATE: begin
          if (hit) begin
            e.status = ST_HIT;
            e.frame  = 4'(hf);
            touch(hf);
            if (w.kind == KIND_CREATE) begin
              dirty_q[hf]   = 1'b1;
              e.fill_action = FILL_ZERO;
            end
          end else begin
            if (next_free < FRAMES) begin
              v = int'(next_free);
              next_free++;
              valid_q[v] = 1'b1;
              for (int g = 0; g < FRAMES; g++)
                if (g != v && valid_q[g]) rank_q[g]++;
              rank_q[v] = '0;
            end else begin
              v = lru_frame();
              if (dirty_q[v]) begin
                e.writeback_valid = 1'b1;
                e.writeback_page  = 32'(tag_q[v]);
              end
              touch(v);
            end
            tag_q[v]      = id;
            dirty_q[v]    = (w.kind == KIND_CREATE);
            e.fill_action = (w.kind == KIND_CREATE) ? FILL_ZERO : FILL_READ;
            e.status      = ST_PLACED;
            e.frame       = 4'(v);
          end
        end
        default: ;
      endcase
      expected_q.insert(expected_q.size(), e);
    endfunction

    function void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t e;
      if (expected_q.size() == 0) begin
        $error("result word with nothing pending: %p", got);
        errors++;
        return;
      end
      e = expected_q[0];
      expected_q.delete(0);
      check_field("status", 32'(e.status), 32'(got.status));
      check_field("frame", 32'(e.frame), 32'(got.frame));
      check_field("writeback_valid", 32'(e.writeback_valid), 32'(got.writeback_valid));
      check_field("writeback_page", e.writeback_page, got.writeback_page);
      check_field("fill_action", 32'(e.fill_action), 32'(got.fill_action));
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  int idle_pct;
  int stall_pct;
  int quiet_cycles;
  tag_t id_pool[POOL_SIZE];

  frame_dir_scoreboard sb = new();

  page_frame_cache_lru_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_word(input logic [1:0] kind, input logic [31:0] page_id);
    in_word_t w;
    w.kind    = kind;
    w.page_id = page_id;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic run_random(input int count, input int idle_in, input int stall_out);
    int          r;
    logic [1:0]  kind;
    logic [31:0] id;
    idle_pct  = idle_in;
    stall_pct = stall_out;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 50)      kind = KIND_FETCH;
      else if (r < 75) kind = KIND_CREATE;
      else if (r < 95) kind = KIND_FLUSH;
      else             kind = KIND_UNUSED;
      // mostly a working set a bit larger than the directory, so hits,
      // evictions and dirty writebacks all happen
      if ($urandom_range(99) < 15) id = $urandom;
      else id = id_pool[$urandom_range(POOL_SIZE - 1)];
      if ($urandom_range(99) < 2) id_pool[$urandom_range(POOL_SIZE - 1)] = $urandom;
      send_word(kind, id);
    end
  endtask

  initial begin
    idle_pct     = 0;
    stall_pct    = 0;
    for (int p = 0; p < POOL_SIZE; p++) id_pool[p] = $urandom;
    id_pool[0] = 32'h0000_0000;
    id_pool[1] = 32'hFFFF_FFFF;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed words
    send_word(KIND_FETCH,  32'h0000_0000);  // miss into first frame
    send_word(KIND_FETCH,  32'h0000_0000);  // hit
    send_word(KIND_CREATE, 32'hFFFF_FFFF);  // new page, zero fill, dirty
    send_word(KIND_FLUSH,  32'hFFFF_FFFF);  // dirty flush
    send_word(KIND_FLUSH,  32'hFFFF_FFFF);  // clean flush still writes back
    send_word(KIND_FLUSH,  32'h1234_5678);  // not resident
    send_word(KIND_UNUSED, 32'h0000_0000);  // unused kind
    send_word(KIND_CREATE, 32'h0000_0000);  // create of a resident id
    for (int i = 0; i < 14; i++)
      send_word((i % 2 == 0) ? KIND_CREATE : KIND_FETCH, 32'h0101_0101 * (i + 2));
    // directory full: clean LRU victim, then a dirty one
    send_word(KIND_FETCH,  32'hAAAA_AAAA);
    send_word(KIND_CREATE, 32'h5555_5555);
    send_word(KIND_FETCH,  32'h8000_0001);

    run_random(375, 0, 0);
    run_random(375, 50, 0);
    run_random(375, 0, 50);
    run_random(375, 6, 6);

    @(negedge clk);
    in_valid  <= 1'b0;
    stall_pct = 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
